### sv/ifrb_pkg.sv
// shared types, sizes and helpers for the idle-framed receive ring buffer
// no dependencies; imported by ifrb_core and the top level
package ifrb_pkg;

  localparam int unsigned RingDepth  = 256;
  localparam int unsigned QueueDepth = 16;

  localparam int unsigned RingAw = $clog2(RingDepth);
  localparam int unsigned LenW   = $clog2(RingDepth + 1);
  localparam int unsigned QAw    = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW   = $clog2(QueueDepth + 1);

  localparam logic [1:0] KindByte = 2'd0;
  localparam logic [1:0] KindIdle = 2'd1;
  localparam logic [1:0] KindRead = 2'd2;

  typedef enum logic [2:0] {
    StAccepted  = 3'd0,
    StDelivered = 3'd1,
    StNoFrame   = 3'd2,
    StDropped   = 3'd3,
    StIgnored   = 3'd4
  } status_e;

  typedef struct packed {
    logic [RingAw-1:0] start;
    logic [LenW-1:0]   len;
  } desc_t;

  typedef struct packed {
    status_e           status;
    logic [7:0]        data;
    logic              last;
    logic [LenW-1:0]   flen;
    logic              ovf;
    logic [CntW-1:0]   pending;
  } res_t;

  function automatic logic [RingAw-1:0] ring_next(input logic [RingAw-1:0] p);
    return (p == RingAw'(RingDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [QAw-1:0] queue_next(input logic [QAw-1:0] q);
    return (q == QAw'(QueueDepth - 1)) ? '0 : q + 1'b1;
  endfunction

endpackage

### sv/ifrb_core.sv
// frame state, byte ring, descriptor queue and first result stage
// depends on ifrb_pkg; holds its result until the next accepted item
module ifrb_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [1:0]     kind_i,
  input  logic [7:0]     rx_byte_i,
  output ifrb_pkg::res_t res_o
);
  import ifrb_pkg::*;

  logic [7:0]        ring_mem [RingDepth];
  desc_t             desc_mem [QueueDepth];

  logic [RingAw-1:0] wp_q, wp_d;
  logic [RingAw-1:0] fs_q, fs_d;
  logic              ovf_q, ovf_d;
  logic [LenW-1:0]   unframed_q, unframed_d;
  logic [QAw-1:0]    head_q, head_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [RingAw-1:0] cursor_q, cursor_d;
  logic [LenW-1:0]   rrem_q, rrem_d;
  logic [LenW-1:0]   rlen_q, rlen_d;

  logic              wr_en, push_en, rd_en, first;
  logic [RingAw-1:0] wp_next, rd_addr;
  logic [LenW-1:0]   rem;
  logic [CntW:0]     tail_sum;
  logic [QAw-1:0]    tail;
  desc_t             head_desc, push_desc;
  res_t              res_d, res_q;
  logic [7:0]        rd_q;

  assign wp_next   = ring_next(wp_q);
  assign head_desc = desc_mem[head_q];
  assign first     = (rrem_q == '0) && (count_q != '0);
  assign rd_addr   = first ? head_desc.start : cursor_q;
  assign rem       = first ? head_desc.len : rrem_q;
  assign tail_sum  = (CntW+1)'(head_q) + (CntW+1)'(count_q);
  assign tail      = (tail_sum >= (CntW+1)'(QueueDepth)) ?
                     QAw'(tail_sum - (CntW+1)'(QueueDepth)) : QAw'(tail_sum);
  assign push_desc = '{start: fs_q, len: unframed_q};

  always_comb begin
    wp_d       = wp_q;
    fs_d       = fs_q;
    ovf_d      = ovf_q;
    unframed_d = unframed_q;
    head_d     = head_q;
    count_d    = count_q;
    cursor_d   = cursor_q;
    rrem_d     = rrem_q;
    rlen_d     = rlen_q;
    wr_en      = 1'b0;
    push_en    = 1'b0;
    rd_en      = 1'b0;
    res_d      = '0;
    res_d.status = StIgnored;
    case (kind_i)
      KindByte: begin
        wr_en = 1'b1;
        wp_d  = wp_next;
        if (unframed_q >= LenW'(RingDepth - 1)) ovf_d = 1'b1;
        // once the ring is full of unframed data the frame start follows the writer
        if (unframed_q == LenW'(RingDepth)) fs_d = wp_next;
        else unframed_d = unframed_q + 1'b1;
        res_d.status = StAccepted;
      end
      KindIdle: begin
        if (unframed_q != '0) begin
          if (count_q == CntW'(QueueDepth)) begin
            res_d.status = StDropped;
          end else begin
            push_en      = 1'b1;
            count_d      = count_q + 1'b1;
            res_d.status = StAccepted;
          end
          fs_d       = wp_q;
          unframed_d = '0;
        end
      end
      KindRead: begin
        if (first) begin
          head_d  = queue_next(head_q);
          count_d = count_q - 1'b1;
          rlen_d  = head_desc.len;
          ovf_d   = 1'b0;
        end
        if (rem == '0) begin
          res_d.status = StNoFrame;
        end else begin
          rd_en        = 1'b1;
          cursor_d     = ring_next(rd_addr);
          rrem_d       = rem - 1'b1;
          res_d.status = StDelivered;
          res_d.last   = (rem == LenW'(1));
          res_d.flen   = first ? head_desc.len : rlen_q;
          res_d.ovf    = first & ovf_q;
        end
      end
      default: res_d.status = StIgnored;
    endcase
    res_d.pending = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      fs_q       <= '0;
      ovf_q      <= 1'b0;
      unframed_q <= '0;
      head_q     <= '0;
      count_q    <= '0;
      cursor_q   <= '0;
      rrem_q     <= '0;
      rlen_q     <= '0;
    end else if (accept_i) begin
      wp_q       <= wp_d;
      fs_q       <= fs_d;
      ovf_q      <= ovf_d;
      unframed_q <= unframed_d;
      head_q     <= head_d;
      count_q    <= count_d;
      cursor_q   <= cursor_d;
      rrem_q     <= rrem_d;
      rlen_q     <= rlen_d;
    end
  end

  // a write and a read never share one item, so no bypass is needed
  always_ff @(posedge clk_i) begin
    if (accept_i && wr_en) ring_mem[wp_q] <= rx_byte_i;
    if (accept_i && rd_en) rd_q <= ring_mem[rd_addr];
    if (accept_i && push_en) desc_mem[tail] <= push_desc;
    if (accept_i) res_q <= res_d;
  end

  always_comb begin
    res_o      = res_q;
    res_o.data = (res_q.status == StDelivered) ? rd_q : 8'h00;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("descriptor count above queue depth");

  a_unframed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unframed_q <= LenW'(RingDepth))
    else $error("unframed count above ring depth");

  a_rem_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rrem_q <= rlen_q)
    else $error("read remaining exceeds open frame length");

  a_idle_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (kind_i == KindIdle) |=> unframed_q == '0)
    else $error("idle event left unframed bytes");

endmodule

### sv/idle_framed_receive_ring_buffer_unit.sv
// Idle-framed receive ring buffer, top level.
// Depends on ifrb_pkg and ifrb_core.
//
// Input channel (in_valid_i / in_stall_o) carries one item: kind_i and
// rx_byte_i. Kind 0 stores a received byte in the 256-byte ring, kind 1
// (line idle) closes the bytes since the last boundary into a frame and
// queues its descriptor (16 deep), kind 2 reads the next byte of the oldest
// frame. Every item yields exactly one result on the output channel
// (out_valid_o / out_stall_i): status, data byte, last mark, frame length,
// the overflow flag on a frame's first byte, and the queued frame count.
//
// The accepting edge updates the state and registers the ring read and the
// result in the first stage; the output register then takes that result when
// the output is empty or not stalled. One item per cycle is taken sustained
// while the receiver does not stall; the single ring port is never contended
// since an item either writes or reads it.
// Reset empties the descriptor queue, clears the pointers and the overflow
// flag; ring and queue contents are left as they are. While the receiver
// stalls, the output holds and one more result waits in the first stage;
// after that in_stall_o rises until the output is taken.
module idle_framed_receive_ring_buffer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    kind_i,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic [7:0]                    data_byte_o,
  output logic                          last_of_frame_o,
  output logic [ifrb_pkg::LenW-1:0]     frame_length_o,
  output logic                          overflow_seen_o,
  output logic [ifrb_pkg::CntW-1:0]     frames_pending_o
);
  import ifrb_pkg::*;

  logic s1_valid_q;
  logic out_valid_q;
  logic advance;
  logic accept;
  res_t s1_res;
  res_t out_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  ifrb_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .kind_i   (kind_i),
    .rx_byte_i(rx_byte_i),
    .res_o    (s1_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) s1_valid_q <= 1'b1;
      else if (advance) s1_valid_q <= 1'b0;
      if (advance) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) out_q <= s1_res;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign data_byte_o      = out_q.data;
  assign last_of_frame_o  = out_q.last;
  assign frame_length_o   = out_q.flen;
  assign overflow_seen_o  = out_q.ovf;
  assign frames_pending_o = out_q.pending;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i && s1_valid_q)
    else $error("input stalled with room in the pipeline");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && advance |=> out_valid_q)
    else $error("first stage item lost on its way to the output");

endmodule
